/* rtl/trie_pkg.sv */
// ----------------------------------------------------------------------------
// trie_pkg
// Shared types and command codes for the prefix trie core.
// ----------------------------------------------------------------------------
package trie_pkg;

  localparam int CMD_W    = 2;
  localparam int LETTER_W = 5;

  // Word commands, taken from the first item of a word
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EXACT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd2;

  // One input item: one letter of a word
  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [LETTER_W-1:0] letter;
    logic                no_letter;
    logic                last;
  } item_t;

  // One result item, given on the last letter of a word
  typedef struct packed {
    logic found;
    logic status;
  } result_t;

endpackage

/* rtl/trie_ram.sv */
// ----------------------------------------------------------------------------
// trie_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module trie_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/trie_insert_and_lookup_core.sv */
// ----------------------------------------------------------------------------
// trie_insert_and_lookup_core
// Prefix trie over a node table: word insert, exact search and prefix search.
// ----------------------------------------------------------------------------
// Words arrive one letter per transfer; the command on the first letter
// applies to the whole word, and one result comes out on the letter marked
// last. The trie lives in two synchronous RAMs: a child link table of
// NODE_COUNT*ALPHABET_SIZE entries and a count table holding the pass and end
// count of each node. Every step waits on a registered RAM read: an insert
// letter runs link read, node allocate and count read, and count write, or
// stops after the link read when it finds the node pool empty; a search
// letter runs the link read only, and an item with no letter, or a letter
// skipped after a missing link or an exhausted pool, reads nothing. The last
// item of a word adds the end count read and the result (the result register
// may wait for the sink). After reset the core clears both tables, one link
// entry per cycle, and accepts no item until every link entry is cleared.
module trie_insert_and_lookup_core
  import trie_pkg::*;
#(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int LINK_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int CNT_W      = 2 * COUNT_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LINK, S_PASS, S_FIN_RD, S_FIN, S_DONE
  } state_t;

  state_t               state;
  logic [LINK_AW-1:0]   clr_idx;
  logic                 in_word;
  logic [CMD_W-1:0]     act_cmd;
  logic [NODE_W-1:0]    cur;
  logic                 miss;
  logic                 ovf;
  logic [FREE_W-1:0]    free_node;
  logic                 is_last;
  logic [LINK_AW-1:0]   slot;
  result_t              res_hold;

  // RAM ports
  logic                 link_we;
  logic [LINK_AW-1:0]   link_waddr;
  logic [NODE_W-1:0]    link_wdata;
  logic                 link_re;
  logic [NODE_W-1:0]    link_rdata;
  logic                 cnt_we;
  logic [NODE_W-1:0]    cnt_waddr;
  logic [CNT_W-1:0]     cnt_wdata;
  logic                 cnt_re;
  logic [NODE_W-1:0]    cnt_raddr;
  logic [CNT_W-1:0]     cnt_rdata;

  // Front-end decode
  logic                 take;
  logic [CMD_W-1:0]     cmd_eff;
  logic [NODE_W-1:0]    cur_eff;
  logic                 miss_eff;
  logic                 ovf_eff;
  logic                 has_letter;
  logic                 walk_ok;
  logic [LINK_AW-1:0]   slot_addr;

  // Link step decode
  logic                 is_insert;
  logic                 no_child;
  logic                 pool_full;
  logic [NODE_W-1:0]    new_node;
  logic [COUNT_BITS-1:0] pass_cnt;
  logic [COUNT_BITS-1:0] end_cnt;
  result_t              res_now;
  logic                 out_free;
  logic                 res_load;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  // Resolve per-word state: a new word starts at the root
  assign item_ready = (state == S_IDLE);
  assign take       = item_valid && item_ready;
  assign cmd_eff    = in_word ? act_cmd : item.command;
  assign cur_eff    = in_word ? cur : '0;
  assign miss_eff   = in_word ? miss : 1'b0;
  assign ovf_eff    = in_word ? ovf : 1'b0;
  assign has_letter = !item.no_letter && (32'(item.letter) < ALPHABET_SIZE);
  assign walk_ok    = has_letter && ((cmd_eff == CMD_INSERT) ? !ovf_eff : !miss_eff);
  assign slot_addr  = LINK_AW'(cur_eff) * LINK_AW'(ALPHABET_SIZE) + LINK_AW'(item.letter);

  assign is_insert  = (act_cmd == CMD_INSERT);
  assign no_child   = (link_rdata == '0);
  assign pool_full  = (free_node >= FREE_W'(NODE_COUNT));
  assign new_node   = no_child ? free_node[NODE_W-1:0] : link_rdata;
  assign pass_cnt   = cnt_rdata[COUNT_BITS-1:0];
  assign end_cnt    = cnt_rdata[CNT_W-1:COUNT_BITS];
  assign out_free   = !result_valid || result_ready;
  assign res_load   = ((state == S_FIN) || (state == S_DONE)) && out_free;

  // Result of a finished word
  always_comb begin
    res_now.found  = 1'b0;
    res_now.status = 1'b0;
    if (is_insert) begin
      res_now.status = ovf;
    end else if (act_cmd == CMD_EXACT) begin
      res_now.found = !miss && (end_cnt != '0);
    end else begin
      res_now.found = !miss && (pass_cnt != '0);
    end
  end

  // Link table access
  always_comb begin
    link_re    = take && walk_ok;
    link_we    = 1'b0;
    link_waddr = slot;
    link_wdata = free_node[NODE_W-1:0];
    if (state == S_CLEAR) begin
      link_we    = 1'b1;
      link_waddr = clr_idx;
      link_wdata = '0;
    end else if (state == S_LINK && is_insert && no_child && !pool_full) begin
      link_we = 1'b1;
    end
  end

  // Count table access
  always_comb begin
    cnt_re    = 1'b0;
    cnt_raddr = cur;
    cnt_we    = 1'b0;
    cnt_waddr = cur;
    cnt_wdata = cnt_rdata;
    case (state)
      S_CLEAR: begin
        cnt_we    = (clr_idx < LINK_AW'(NODE_COUNT));
        cnt_waddr = clr_idx[NODE_W-1:0];
        cnt_wdata = '0;
      end
      S_LINK: begin
        cnt_re    = is_insert && !(no_child && pool_full);
        cnt_raddr = new_node;
      end
      S_PASS: begin
        cnt_we    = 1'b1;
        cnt_wdata = {end_cnt, sat_inc(pass_cnt)};
      end
      S_FIN_RD: begin
        cnt_re = 1'b1;
      end
      S_FIN: begin
        cnt_we    = is_insert && !ovf;
        cnt_wdata = {sat_inc(end_cnt), pass_cnt};
      end
      default: begin
        cnt_re = 1'b0;
      end
    endcase
  end

  trie_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (NODE_W)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (link_re),
    .raddr (slot_addr),
    .rdata (link_rdata)
  );

  trie_ram #(
    .DEPTH (NODE_COUNT),
    .WIDTH (CNT_W)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Sequencer, word state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      in_word      <= 1'b0;
      act_cmd      <= CMD_INSERT;
      cur          <= '0;
      miss         <= 1'b0;
      ovf          <= 1'b0;
      free_node    <= FREE_W'(1);
      is_last      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Raise the result on load, drop it once transferred
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LINK_AW'(LINK_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            in_word <= 1'b1;
            act_cmd <= cmd_eff;
            cur     <= cur_eff;
            miss    <= miss_eff;
            ovf     <= ovf_eff;
            is_last <= item.last;
            slot    <= slot_addr;
            if (walk_ok) begin
              state <= S_LINK;
            end else if (item.last) begin
              state <= S_FIN_RD;
            end
          end
        end
        S_LINK: begin
          if (is_insert) begin
            if (no_child && pool_full) begin
              ovf   <= 1'b1;
              state <= is_last ? S_FIN_RD : S_IDLE;
            end else begin
              if (no_child) begin
                free_node <= free_node + 1'b1;
              end
              cur   <= new_node;
              state <= S_PASS;
            end
          end else begin
            if (no_child) begin
              miss <= 1'b1;
            end else begin
              cur <= link_rdata;
            end
            state <= is_last ? S_FIN_RD : S_IDLE;
          end
        end
        S_PASS: begin
          state <= is_last ? S_FIN_RD : S_IDLE;
        end
        S_FIN_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          in_word <= 1'b0;
          if (out_free) begin
            result <= res_now;
            state  <= S_IDLE;
          end else begin
            res_hold <= res_now;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            result <= res_hold;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
